// ----- src/izhikevich_neuron_euler_assert.svh -----
// ----------------------------------------------------------------------------
// izhikevich neuron assertion macros
// concurrent assertion wrappers; they compile away under synthesis
// ----------------------------------------------------------------------------
`ifndef IZHIKEVICH_NEURON_EULER_ASSERT_SVH
`define IZHIKEVICH_NEURON_EULER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IZN_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("izhikevich neuron assertion failed");

// next-cycle implication
`define IZN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("izhikevich neuron assertion failed");

`else

`define IZN_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define IZN_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- src/izn_pkg.sv -----
// ----------------------------------------------------------------------------
// izn_pkg
// types and fixed-point constants shared by the izhikevich neuron block
// ----------------------------------------------------------------------------
package izn_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_WIDTH = 32;
   localparam int DT_WIDTH   = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int ONE_FX     = 1 << FRAC_BITS;

   typedef logic signed [DATA_WIDTH-1:0] fx_type;

   // round(0.04), round(0.02), round(0.2) in fixed point
   localparam fx_type K_QUAD    = fx_type'(((4 << FRAC_BITS) + 50) / 100);
   localparam fx_type A_RESET   = fx_type'(((2 << FRAC_BITS) + 50) / 100);
   localparam fx_type B_RESET   = fx_type'(((2 << FRAC_BITS) + 5) / 10);
   localparam fx_type C_RESET   = fx_type'(-65 * ONE_FX);
   localparam fx_type D_RESET   = fx_type'(8 * ONE_FX);
   localparam fx_type H_RESET   = fx_type'(30 * ONE_FX);
   localparam fx_type C_140     = fx_type'(140 * ONE_FX);
   localparam fx_type U_RESTART = fx_type'(-14 * ONE_FX);
   localparam logic [DT_WIDTH-1:0] DT_RESET = DT_WIDTH'(ONE_FX);

   localparam fx_type FX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam fx_type FX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY_RATE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY_SENSITIVITY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_POTENTIAL      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY_JUMP        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIKE_PEAK           = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE            = 3'd5;

   typedef struct packed {
      logic signed [31:0] applied_current;
      logic               restart;
   } req_type;

   typedef struct packed {
      logic signed [31:0] potential;
      logic signed [31:0] recovery;
      logic               spike;
      logic               last;
   } rsp_type;

   // datapath micro-operations, one per cycle while the sequencer is not idle or held by a stalled result register
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_KV,
      OP_KVV,
      OP_BV,
      OP_DIFF,
      OP_MUL_A,
      OP_SUBU,
      OP_ADDI,
      OP_MUL_DV,
      OP_MUL_DU,
      OP_U1,
      OP_ROW,
      OP_RESET_ROW
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic spike;
   } dp_status_type;

endpackage

// ----- src/izn_dpath.sv -----
// ----------------------------------------------------------------------------
// izn_dpath
// state, config registers, one shared multiplier, one shared saturating adder and a clamped 5*v adder
// ----------------------------------------------------------------------------
module izn_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  izn_pkg::dp_cmd_type              cmd,
   output izn_pkg::dp_status_type           status,
   input  izn_pkg::req_type                 req_data,
   output izn_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [izn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_wdata
);
   import izn_pkg::*;

   localparam int PW = 2 * DATA_WIDTH;
   localparam logic signed [PW-1:0] P_MAX = {{(PW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [PW-1:0] P_MIN = {{(PW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

   // configuration
   fx_type a_ff, b_ff, c_ff, d_ff, h_ff;
   logic [DT_WIDTH-1:0] dt_ff;

   // neuron state and working registers
   fx_type v_ff, v_in, u_ff, u_in;
   fx_type acc_ff, acc_in, aux_ff, aux_in, cur_ff, cur_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   rsp_type rsp_ff, rsp_in;

   // multiplier and adder operands
   fx_type mul_a, mul_b, add_a, add_b;
   logic   add_sub;
   fx_type prod_sat, sum_sat, five_v;
   logic signed [PW-1:0]         prod_shift;
   logic signed [DATA_WIDTH:0]   sum_wide;
   logic signed [DATA_WIDTH+2:0] five_wide;
   logic spike;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff  <= A_RESET;
         b_ff  <= B_RESET;
         c_ff  <= C_RESET;
         d_ff  <= D_RESET;
         h_ff  <= H_RESET;
         dt_ff <= DT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RECOVERY_RATE:        a_ff  <= csr_wdata;
            CSR_RECOVERY_SENSITIVITY: b_ff  <= csr_wdata;
            CSR_RESET_POTENTIAL:      c_ff  <= csr_wdata;
            CSR_RECOVERY_JUMP:        d_ff  <= csr_wdata;
            CSR_SPIKE_PEAK:           h_ff  <= csr_wdata;
            CSR_STEP_SIZE:            dt_ff <= csr_wdata[DT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= C_RESET;
         u_ff <= U_RESTART;
      end else begin
         v_ff <= v_in;
         u_ff <= u_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      aux_ff  <= aux_in;
      cur_ff  <= cur_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   // floor shift of the product, then saturate
   assign prod_shift = prod_ff >>> FRAC_BITS;
   always_comb begin
      if (prod_shift > P_MAX) begin
         prod_sat = FX_MAX;
      end else if (prod_shift < P_MIN) begin
         prod_sat = FX_MIN;
      end else begin
         prod_sat = prod_shift[DATA_WIDTH-1:0];
      end
   end

   // saturating add / subtract
   always_comb begin
      if (add_sub) begin
         sum_wide = {add_a[DATA_WIDTH-1], add_a} - {add_b[DATA_WIDTH-1], add_b};
      end else begin
         sum_wide = {add_a[DATA_WIDTH-1], add_a} + {add_b[DATA_WIDTH-1], add_b};
      end
      if (sum_wide[DATA_WIDTH] != sum_wide[DATA_WIDTH-1]) begin
         sum_sat = sum_wide[DATA_WIDTH] ? FX_MIN : FX_MAX;
      end else begin
         sum_sat = sum_wide[DATA_WIDTH-1:0];
      end
   end

   // 5*v clamped; same as the chain of saturating adds since all terms share a sign
   always_comb begin
      five_wide = {{3{v_ff[DATA_WIDTH-1]}}, v_ff} + {v_ff[DATA_WIDTH-1], v_ff, 2'b00};
      if (five_wide[DATA_WIDTH+2:DATA_WIDTH-1] != {4{five_wide[DATA_WIDTH+2]}}) begin
         five_v = five_wide[DATA_WIDTH+2] ? FX_MIN : FX_MAX;
      end else begin
         five_v = five_wide[DATA_WIDTH-1:0];
      end
   end

   assign spike        = (acc_ff >= h_ff);
   assign status.spike = spike;

   always_comb begin
      v_in    = v_ff;
      u_in    = u_ff;
      acc_in  = acc_ff;
      aux_in  = aux_ff;
      cur_in  = cur_ff;
      rsp_in  = rsp_ff;
      mul_a   = v_ff;
      mul_b   = v_ff;
      add_a   = acc_ff;
      add_b   = aux_ff;
      add_sub = 1'b0;
      prod_in = prod_ff;
      case (cmd.op)
         OP_LOAD: begin
            cur_in = req_data.applied_current;
            if (req_data.restart) begin
               v_in = c_ff;
               u_in = U_RESTART;
            end
         end
         OP_KV: begin
            mul_a   = K_QUAD;
            prod_in = mul_a * mul_b;
         end
         OP_KVV: begin
            mul_a   = prod_sat;
            prod_in = mul_a * mul_b;
         end
         OP_BV: begin
            mul_a   = b_ff;
            prod_in = mul_a * mul_b;
            add_a   = prod_sat;
            add_b   = five_v;
            acc_in  = sum_sat;
         end
         OP_DIFF: begin
            add_a   = prod_sat;
            add_b   = u_ff;
            add_sub = 1'b1;
            aux_in  = sum_sat;
         end
         OP_MUL_A: begin
            mul_a   = a_ff;
            mul_b   = aux_ff;
            prod_in = mul_a * mul_b;
            add_b   = C_140;
            acc_in  = sum_sat;
         end
         OP_SUBU: begin
            add_b   = u_ff;
            add_sub = 1'b1;
            acc_in  = sum_sat;
            aux_in  = prod_sat;
         end
         OP_ADDI: begin
            add_b  = cur_ff;
            acc_in = sum_sat;
         end
         OP_MUL_DV: begin
            mul_a   = {1'b0, dt_ff};
            mul_b   = acc_ff;
            prod_in = mul_a * mul_b;
         end
         OP_MUL_DU: begin
            mul_a   = {1'b0, dt_ff};
            mul_b   = aux_ff;
            prod_in = mul_a * mul_b;
            add_a   = v_ff;
            add_b   = prod_sat;
            acc_in  = sum_sat;
         end
         OP_U1: begin
            add_a  = u_ff;
            add_b  = prod_sat;
            aux_in = sum_sat;
         end
         OP_ROW: begin
            add_a = aux_ff;
            add_b = d_ff;
            if (spike) begin
               rsp_in = '{potential: h_ff, recovery: aux_ff, spike: 1'b1, last: 1'b0};
               v_in   = c_ff;
               u_in   = sum_sat;
            end else begin
               rsp_in = '{potential: acc_ff, recovery: aux_ff, spike: 1'b0, last: 1'b1};
               v_in   = acc_ff;
               u_in   = aux_ff;
            end
         end
         OP_RESET_ROW: begin
            rsp_in = '{potential: v_ff, recovery: u_ff, spike: 1'b0, last: 1'b1};
         end
         default: ;
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- src/izn_ctrl.sv -----
// ----------------------------------------------------------------------------
// izn_ctrl
// sequencer for one euler step and the result handshake
// ----------------------------------------------------------------------------
module izn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output izn_pkg::dp_cmd_type    cmd,
   input  izn_pkg::dp_status_type status
);
   import izn_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_KV     = 13'b0000000000010,
      ST_KVV    = 13'b0000000000100,
      ST_BV     = 13'b0000000001000,
      ST_DIFF   = 13'b0000000010000,
      ST_MUL_A  = 13'b0000000100000,
      ST_SUBU   = 13'b0000001000000,
      ST_ADDI   = 13'b0000010000000,
      ST_MUL_DV = 13'b0000100000000,
      ST_MUL_DU = 13'b0001000000000,
      ST_U1     = 13'b0010000000000,
      ST_ROW    = 13'b0100000000000,
      ST_RESET  = 13'b1000000000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_load;
   logic      slot_free;

   // output register can take a new beat
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_KV;
            end
         end
         ST_KV: begin
            cmd.op   = OP_KV;
            state_in = ST_KVV;
         end
         ST_KVV: begin
            cmd.op   = OP_KVV;
            state_in = ST_BV;
         end
         ST_BV: begin
            cmd.op   = OP_BV;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.op   = OP_MUL_A;
            state_in = ST_SUBU;
         end
         ST_SUBU: begin
            cmd.op   = OP_SUBU;
            state_in = ST_ADDI;
         end
         ST_ADDI: begin
            cmd.op   = OP_ADDI;
            state_in = ST_MUL_DV;
         end
         ST_MUL_DV: begin
            cmd.op   = OP_MUL_DV;
            state_in = ST_MUL_DU;
         end
         ST_MUL_DU: begin
            cmd.op   = OP_MUL_DU;
            state_in = ST_U1;
         end
         ST_U1: begin
            cmd.op   = OP_U1;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            if (slot_free) begin
               cmd.op   = OP_ROW;
               rsp_load = 1'b1;
               state_in = status.spike ? ST_RESET : ST_IDLE;
            end
         end
         ST_RESET: begin
            if (slot_free) begin
               cmd.op   = OP_RESET_ROW;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/izhikevich_neuron_euler.sv -----
// izhikevich neuron, one forward euler step per request beat
// a new request is taken only once the previous step is done and its result beats are loaded
// a spiking step gives two result beats (peak row, then reset row), else one
// the step runs as a sequence of micro-ops on one shared 32x32 multiplier and adder
// reset (synchronous): v = -65, u = -14, config registers to their defaults
// ----------------------------------------------------------------------------
// izhikevich_neuron_euler
// top level: sequencer plus fixed-point datapath
// ----------------------------------------------------------------------------
module izhikevich_neuron_euler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  izn_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output izn_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [izn_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);
   import izn_pkg::*;

`include "izhikevich_neuron_euler_assert.svh"

   dp_cmd_type    cmd;
   dp_status_type status;

   izn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   izn_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // one step at a time: the input closes after a beat is taken
   `IZN_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a peak row is followed at once by the final reset row
   `IZN_ASSERT_NEXT(a_reset_row_follows, clock, reset, rsp_valid && !rsp_stall && rsp_data.spike, rsp_valid && rsp_data.last && !rsp_data.spike)

   // every row is either a peak row or a final row, never both
   `IZN_ASSERT_IMPL(a_row_kind, clock, reset, rsp_valid, rsp_data.spike != rsp_data.last)

endmodule

// ----- tb/sv/tb_izhikevich_neuron_euler.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_izhikevich_neuron_euler
// self-checking bench: a directed table with a few hand-typed rows, then
// random current beats under changing neuron settings; every result beat is
// compared with an in-bench fixed-point euler model of the neuron
// ----------------------------------------------------------------------------
module tb_izhikevich_neuron_euler;
   import izn_pkg::*;

   localparam longint LIMIT_NS    = 20_000_000;
   localparam int     DRAIN_LIMIT = 5000;
   localparam int     NUM_PLAN    = 35;
   localparam int     NUM_PHASES  = 12;
   localparam int     PHASE_ITEMS = 120;

   // indexes past the register list, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   localparam logic [31:0]        W_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0]        W_MIN  = 32'h8000_0000;
   localparam logic [31:0]        W_ONES = 32'hFFFF_FFFF;
   localparam logic signed [31:0] I_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] I_MIN  = 32'sh8000_0000;
   localparam logic signed [31:0] I_ZERO = 32'sd0;
   localparam logic signed [31:0] I_FIVE = 5 * ONE_FX;
   localparam logic signed [31:0] I_TEN  = 10 * ONE_FX;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum int {SET_TUNED, SET_DEFAULT, SET_RANDOM, SET_EXTREME} setting_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [31:0]           wdata;
      req_type               beat;
      bit                    typed;
      bit                    fires;
      logic [31:0]           pot_first;
      logic [31:0]           pot_second;
   } plan_row_type;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   // neuron settings and state as the bench tracks them
   longint rate_a, sens_b, reset_c, jump_d, peak_h, dt_step;
   longint v_state, u_state;
   rsp_type pending_rows [$];
   int fail_count = 0;
   int stall_left = 0;
   bit quiet      = 1'b0;

   plan_row_type plan [NUM_PLAN] = '{
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_MAX, 1'b1}, 1'b1, 1'b1, H_RESET, C_RESET},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_MIN, 1'b1}, 1'b1, 1'b0, FX_MIN, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_MAX, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{-32'sd1, 1'b1}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_TEN, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_TEN, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_TEN, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_TEN, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_TEN, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_TEN, 1'b0}, 1'b0, 1'b0, '0, '0},
      // zero step: state holds, yet the spike test is still made
      '{ROW_CSR, CSR_STEP_SIZE, '0, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_MAX, 1'b1}, 1'b1, 1'b0, C_RESET, '0},
      '{ROW_CSR, CSR_SPIKE_PEAK, W_MIN, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_ZERO, 1'b0}, 1'b1, 1'b1, FX_MIN, C_RESET},
      '{ROW_CSR, CSR_UNMAPPED_LO, W_ONES, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_UNMAPPED_HI, 32'h1234_5678, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_STEP_SIZE, W_ONES, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_SPIKE_PEAK, W_MAX, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_RECOVERY_RATE, W_MAX, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_RECOVERY_SENSITIVITY, W_MIN, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_RESET_POTENTIAL, W_MAX, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_RECOVERY_JUMP, W_MIN, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_ZERO, 1'b1}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_MIN, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_MAX, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_RECOVERY_RATE, W_MIN, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_RECOVERY_SENSITIVITY, W_MAX, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_RESET_POTENTIAL, W_MIN, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_RECOVERY_JUMP, W_MAX, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_SPIKE_PEAK, '0, '{I_ZERO, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_ZERO, 1'b1}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_FIVE, 1'b0}, 1'b0, 1'b0, '0, '0},
      '{ROW_ITEM, CSR_RECOVERY_RATE, '0, '{I_MIN, 1'b1}, 1'b0, 1'b0, '0, '0}
   };

   izhikevich_neuron_euler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #LIMIT_NS;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint sat_word(longint x);
      if (x > longint'(FX_MAX)) return longint'(FX_MAX);
      if (x < longint'(FX_MIN)) return longint'(FX_MIN);
      return x;
   endfunction

   function automatic longint sat_add(longint x, longint y);
      return sat_word(x + y);
   endfunction

   function automatic longint sat_sub(longint x, longint y);
      return sat_word(x - y);
   endfunction

   // exact product, floor shift, saturate
   function automatic longint fx_mul(longint x, longint y);
      return sat_word((x * y) >>> FRAC_BITS);
   endfunction

   // one euler step on the tracked state, queues the rows it should produce
   function automatic void advance_neuron(req_type beat);
      longint cur, v, u, dv, du, v_next, u_next, five_v;
      rsp_type row;
      cur = beat.applied_current;
      if (beat.restart) begin
         v_state = reset_c;
         u_state = U_RESTART;
      end
      v = v_state;
      u = u_state;
      five_v = v;
      repeat (4) five_v = sat_add(five_v, v);
      dv = fx_mul(fx_mul(K_QUAD, v), v);
      dv = sat_add(dv, five_v);
      dv = sat_add(dv, C_140);
      dv = sat_sub(dv, u);
      dv = sat_add(dv, cur);
      du = fx_mul(rate_a, sat_sub(fx_mul(sens_b, v), u));
      v_next = sat_add(v, fx_mul(dt_step, dv));
      u_next = sat_add(u, fx_mul(dt_step, du));
      if (v_next >= peak_h) begin
         row.potential = peak_h[31:0];
         row.recovery  = u_next[31:0];
         row.spike     = 1'b1;
         row.last      = 1'b0;
         pending_rows = {pending_rows, row};
         v_state = reset_c;
         u_state = sat_add(u_next, jump_d);
         row.spike = 1'b0;
         row.last  = 1'b1;
      end else begin
         v_state = v_next;
         u_state = u_next;
         row.spike = 1'b0;
         row.last  = 1'b1;
      end
      row.potential = v_state[31:0];
      row.recovery  = u_state[31:0];
      pending_rows = {pending_rows, row};
   endfunction

   // mostly no pause, sometimes short, rarely long
   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      if (r < 98) return $urandom_range(5, 16);
      return $urandom_range(17, 40);
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return W_MIN;
         1: return W_MAX;
         2: return '0;
         3: return W_ONES;
         default: return ONE_FX;
      endcase
   endfunction

   task automatic drive_request(plan_row_type row);
      int gap;
      int n;
      rsp_type patched;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= row.beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_neuron(row.beat);
      // hand-typed rows override the predicted potential and flags
      if (row.typed) begin
         n = pending_rows.size();
         patched = pending_rows[n-1];
         patched.potential = row.fires ? row.pot_second : row.pot_first;
         patched.spike = 1'b0;
         patched.last  = 1'b1;
         pending_rows[n-1] = patched;
         if (row.fires) begin
            patched = pending_rows[n-2];
            patched.potential = row.pot_first;
            patched.spike = 1'b1;
            patched.last  = 1'b0;
            pending_rows[n-2] = patched;
         end
      end
      gap = pause_len();
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_rows();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rows.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_RECOVERY_RATE:        rate_a  = $signed(data);
         CSR_RECOVERY_SENSITIVITY: sens_b  = $signed(data);
         CSR_RESET_POTENTIAL:      reset_c = $signed(data);
         CSR_RECOVERY_JUMP:        jump_d  = $signed(data);
         CSR_SPIKE_PEAK:           peak_h  = $signed(data);
         CSR_STEP_SIZE:            dt_step = data[DT_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_setting(setting_type mode);
      logic [31:0] setting [2**CSR_IDX_W];
      int k;
      case (mode)
         SET_TUNED: begin
            setting[CSR_RECOVERY_RATE]        = $urandom_range(655, 6554);
            setting[CSR_RECOVERY_SENSITIVITY] = $urandom_range(13107, 16384);
            setting[CSR_RESET_POTENTIAL]      = -($urandom_range(50, 65) * ONE_FX);
            setting[CSR_RECOVERY_JUMP]        = $urandom_range(3277, 8 * ONE_FX);
            setting[CSR_SPIKE_PEAK]           = H_RESET;
            setting[CSR_STEP_SIZE]            = $urandom_range(4096, ONE_FX);
         end
         SET_DEFAULT: begin
            setting[CSR_RECOVERY_RATE]        = A_RESET;
            setting[CSR_RECOVERY_SENSITIVITY] = B_RESET;
            setting[CSR_RESET_POTENTIAL]      = C_RESET;
            setting[CSR_RECOVERY_JUMP]        = D_RESET;
            setting[CSR_SPIKE_PEAK]           = H_RESET;
            setting[CSR_STEP_SIZE]            = 32'(DT_RESET);
         end
         SET_RANDOM: begin
            for (k = CSR_RECOVERY_RATE; k <= CSR_STEP_SIZE; k++) setting[k] = $urandom;
         end
         default: begin
            for (k = CSR_RECOVERY_RATE; k < CSR_STEP_SIZE; k++) setting[k] = pick_extreme();
            case ($urandom_range(0, 3))
               0: setting[CSR_STEP_SIZE] = '0;
               1: setting[CSR_STEP_SIZE] = 32'd1;
               2: setting[CSR_STEP_SIZE] = W_MAX;
               default: setting[CSR_STEP_SIZE] = ONE_FX;
            endcase
         end
      endcase
      for (k = CSR_RECOVERY_RATE; k <= CSR_STEP_SIZE; k++)
         write_register(CSR_IDX_W'(k), setting[k]);
   endtask

   // result side back-pressure
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) stall_left = pause_len();
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rows.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result beat: v=%0d u=%0d spike=%0b last=%0b",
                        rsp_data.potential, rsp_data.recovery, rsp_data.spike,
                        rsp_data.last);
         end else begin
            want = pending_rows.pop_front();
            if (rsp_data.potential !== want.potential || rsp_data.recovery !== want.recovery
                || rsp_data.spike !== want.spike || rsp_data.last !== want.last) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch: expected v=%0d u=%0d spike=%0b last=%0b",
                           want.potential, want.recovery, want.spike, want.last);
                  $display("          got      v=%0d u=%0d spike=%0b last=%0b",
                           rsp_data.potential, rsp_data.recovery, rsp_data.spike,
                           rsp_data.last);
               end
            end
         end
      end
   end

   initial begin
      plan_row_type stim;
      int i, phase, item;
      rate_a  = A_RESET;
      sens_b  = B_RESET;
      reset_c = C_RESET;
      jump_d  = D_RESET;
      peak_h  = H_RESET;
      dt_step = DT_RESET;
      v_state = C_RESET;
      u_state = U_RESTART;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_PLAN; i++) begin
         if (plan[i].kind == ROW_CSR) begin
            drain_rows();
            write_register(plan[i].index, plan[i].wdata);
         end else begin
            drive_request(plan[i]);
         end
      end

      stim.kind       = ROW_ITEM;
      stim.index      = CSR_RECOVERY_RATE;
      stim.wdata      = '0;
      stim.typed      = 1'b0;
      stim.fires      = 1'b0;
      stim.pot_first  = '0;
      stim.pot_second = '0;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_rows();
         quiet = 1'b0;
         load_setting(setting_type'(phase % 4));
         quiet = (phase % 3 == 1);
         for (item = 0; item < PHASE_ITEMS; item++) begin
            // mostly plausible drive currents so the neuron actually fires
            if ($urandom_range(0, 99) < 85) begin
               stim.beat.applied_current = $urandom_range(0, 25 * ONE_FX) - 5 * ONE_FX;
               stim.beat.restart = (item == 0) || ($urandom_range(0, 39) == 0);
            end else begin
               stim.beat.applied_current = $urandom;
               stim.beat.restart = $urandom_range(0, 1);
            end
            drive_request(stim);
         end
      end

      quiet = 1'b0;
      drain_rows();
      repeat (30) @(posedge clock);
      fail_count += pending_rows.size();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
